@@ design/framed_message_ring_producer_top_assert.svh @@
// Assertion macros for the framed message ring producer.
`ifndef FRAMED_MESSAGE_RING_PRODUCER_TOP_ASSERT_SVH
`define FRAMED_MESSAGE_RING_PRODUCER_TOP_ASSERT_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset.
`define FMRP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequent in the same cycle as its trigger.
`define FMRP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its trigger.
`define FMRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FMRP_ASSERT(label, cond, msg)
`define FMRP_ASSERT_IMP(label, ante, cons, msg)
`define FMRP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ design/fmrp_pkg.sv @@
// Types and constants of the framed message ring producer.
package fmrp_pkg;

    localparam int MAX_SEGMENTS  = 8;
    localparam int OFFSET_BITS   = 24;
    localparam int SIZE_BITS     = OFFSET_BITS + 1;
    localparam int HEADER_BYTES  = 16;
    localparam int MAX_MSG_LEN   = 65519;
    localparam int RING_RESET    = 4096;
    localparam int RING_REG_BITS = 25;
    localparam int ADV_BITS      = 17;
    localparam int MAX_RESULTS   = 4;
    localparam int IN_DATA_BITS  = 160;
    localparam int OUT_DATA_BITS = 96;

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic [2:0] REG_RING_BYTES = 3'd0;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_BYTE   = 2'd2,
        KIND_COMMIT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_INTEGRITY = 2'd3
    } status_t;

    typedef struct packed {
        kind_t                   kind;
        status_t                 status;
        logic [OFFSET_BITS-1:0]  offset;
        logic [63:0]             data;
        logic                    last;
    } res_t;

endpackage

@@ design/framed_message_ring_producer_top.sv @@
// Framed message ring producer: checks, header writes, payload writes and head commits.
//
// Producer side of a byte ring of framed messages. Items pass an input register, then one
// level of logic that checks a begin item (length and segment limits, free space, head
// sanity) or places a payload byte, and land in a four-word result buffer that drains one
// word per cycle while m_tready is high. A payload byte streams back to back; the closing
// byte of a message yields two words. A begin item yields one status word when refused,
// else three words, four for an empty message, so it holds the input register while the
// result buffer drains. The ring size register at address 0 is written over the APB port;
// the user must write it only while the block is idle, as the block does not enforce it.
module framed_message_ring_producer_top
    import fmrp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // tuser: op
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic                      s_tuser,
    // tdata: tag[63:0], msg_len[79:64], segments[83:80], tail[147:84],
    // data_byte[155:148], zero fill above
    input  logic [IN_DATA_BITS-1:0]   s_tdata,
    // tuser: kind
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [1:0]                m_tuser,
    // tdata: status[1:0], offset[25:2], data[89:26], zero fill above
    output logic [OUT_DATA_BITS-1:0]  m_tdata,
    output logic                      m_tlast,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    `include "framed_message_ring_producer_top_assert.svh"

    // configuration
    logic [RING_REG_BITS-1:0] ring_bytes_reg;
    logic                     cfg_wr;

    // input register
    logic                     in_valid_reg;
    logic                     in_valid_next;
    logic                     in_op_reg;
    logic [63:0]              in_tag_reg;
    logic [15:0]              in_len_reg;
    logic [3:0]               in_segs_reg;
    logic [63:0]              in_tail_reg;
    logic [7:0]               in_byte_reg;

    // ring state
    logic [63:0]              head_position_reg;
    logic [63:0]              head_position_next;
    logic [OFFSET_BITS-1:0]   write_offset_reg;
    logic [OFFSET_BITS-1:0]   write_offset_next;
    logic [OFFSET_BITS-1:0]   next_start_reg;
    logic [OFFSET_BITS-1:0]   next_start_next;
    logic                     message_open_reg;
    logic                     message_open_next;
    logic [15:0]              bytes_left_reg;
    logic [15:0]              bytes_left_next;
    logic [ADV_BITS-1:0]      pending_adv_reg;
    logic [ADV_BITS-1:0]      pending_adv_next;

    // result buffer
    res_t                     res_reg [MAX_RESULTS];
    res_t                     res_next [MAX_RESULTS];
    logic [2:0]               res_rem_reg;
    logic [1:0]               res_idx_reg;
    logic [2:0]               res_cnt;
    res_t                     res_out;

    // datapath
    logic                     out_free;
    logic                     load;
    logic [SIZE_BITS-1:0]     ring_trunc;
    logic [SIZE_BITS-1:0]     size_eff;
    logic [ADV_BITS-1:0]      rounded;
    logic [64:0]              head_minus_tail;
    logic [64:0]              head_sum;
    logic [SIZE_BITS-1:0]     space_left;
    logic [OFFSET_BITS-1:0]   start_off;
    logic [OFFSET_BITS-1:0]   len_off;
    logic [OFFSET_BITS-1:0]   byte_pos;
    logic                     bad_args;
    logic                     too_big;
    logic                     bad_head;
    logic                     too_full;
    logic                     last_byte;
    logic [63:0]              head_commit;

    function automatic logic [OFFSET_BITS-1:0] wrap_add(
        input logic [SIZE_BITS-1:0] pos,
        input logic [SIZE_BITS-1:0] amount,
        input logic [SIZE_BITS-1:0] size
    );
        logic [SIZE_BITS:0] x;
        x = {1'b0, pos} + {1'b0, amount};
        if (x >= {1'b0, size})
        begin
            x = x - {1'b0, size};
        end
        return x[OFFSET_BITS-1:0];
    endfunction

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_RING_BYTES[2]) ? 32'(ring_bytes_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_bytes_reg <= RING_REG_BITS'(RING_RESET);
        end
        else if (cfg_wr && paddr[2] == REG_RING_BYTES[2])
        begin
            ring_bytes_reg <= pwdata[RING_REG_BITS-1:0];
        end
    end

    // ---------------- handshake ----------------
    assign out_free = (res_rem_reg == 3'd0) || (res_rem_reg == 3'd1 && m_tready);
    assign load     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_tag_reg  <= s_tdata[63:0];
            in_len_reg  <= s_tdata[79:64];
            in_segs_reg <= s_tdata[83:80];
            in_tail_reg <= s_tdata[147:84];
            in_byte_reg <= s_tdata[155:148];
        end
    end

    // ---------------- item logic ----------------
    assign ring_trunc = {ring_bytes_reg[RING_REG_BITS-1:3], 3'b000};

    always_comb
    begin
        size_eff = ring_trunc;
        if (ring_trunc < SIZE_BITS'(8))
        begin
            size_eff = SIZE_BITS'(8);
        end
        else if (ring_trunc > (SIZE_BITS'(1) << OFFSET_BITS))
        begin
            size_eff = SIZE_BITS'(1) << OFFSET_BITS;
        end
    end

    assign rounded = ({1'b0, in_len_reg} + ADV_BITS'(HEADER_BYTES + 7))
                     & ~ADV_BITS'(7);
    assign head_minus_tail = {1'b0, head_position_reg} - {1'b0, in_tail_reg};
    assign head_sum        = {1'b0, head_position_reg} + 65'(rounded);
    assign space_left      = size_eff - SIZE_BITS'(rounded);

    assign bad_args = message_open_reg || (in_segs_reg > 4'(MAX_SEGMENTS))
                      || (in_len_reg > 16'(MAX_MSG_LEN));
    assign too_big  = SIZE_BITS'(rounded) > size_eff;
    assign bad_head = head_minus_tail[64] || head_sum[64] || (head_position_reg[2:0] != 3'd0);
    assign too_full = head_minus_tail[63:0] > 64'(space_left);

    assign start_off = ({1'b0, next_start_reg} >= size_eff) ? '0 : next_start_reg;
    assign len_off   = wrap_add({1'b0, start_off}, SIZE_BITS'(8), size_eff);
    assign byte_pos  = ({1'b0, write_offset_reg} >= size_eff) ? '0 : write_offset_reg;
    assign last_byte = bytes_left_reg <= 16'd1;
    assign head_commit = head_position_reg + 64'(pending_adv_reg);

    always_comb
    begin
        head_position_next = head_position_reg;
        write_offset_next  = write_offset_reg;
        next_start_next    = next_start_reg;
        message_open_next  = message_open_reg;
        bytes_left_next    = bytes_left_reg;
        pending_adv_next   = pending_adv_reg;
        res_cnt            = 3'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_next[i] = res_reg[i];
        end

        if (in_op_reg == OP_BEGIN)
        begin
            res_cnt     = 3'd1;
            res_next[0] = '{kind: KIND_STATUS, status: ST_OK, offset: '0, data: '0, last: 1'b1};
            if (bad_args)
            begin
                res_next[0].status = ST_INVALID;
            end
            else if (too_big)
            begin
                res_next[0].status = ST_NO_SPACE;
            end
            else if (bad_head)
            begin
                res_next[0].status = ST_INTEGRITY;
            end
            else if (too_full)
            begin
                res_next[0].status = ST_NO_SPACE;
            end
            else
            begin
                res_cnt          = 3'd3;
                res_next[0].last = 1'b0;
                res_next[1] = '{kind: KIND_WORD, status: ST_OK, offset: start_off,
                                data: in_tag_reg, last: 1'b0};
                res_next[2] = '{kind: KIND_WORD, status: ST_OK, offset: len_off,
                                data: 64'(in_len_reg), last: (in_len_reg == 16'd0)};
                write_offset_next = wrap_add({1'b0, len_off}, SIZE_BITS'(8), size_eff);
                next_start_next   = wrap_add({1'b0, start_off}, SIZE_BITS'(rounded), size_eff);
                if (in_len_reg == 16'd0)
                begin
                    // empty message commits right away
                    res_cnt            = 3'd4;
                    head_position_next = head_sum[63:0];
                    res_next[3] = '{kind: KIND_COMMIT, status: ST_OK, offset: '0,
                                    data: head_sum[63:0], last: 1'b1};
                end
                else
                begin
                    message_open_next = 1'b1;
                    bytes_left_next   = in_len_reg;
                    pending_adv_next  = rounded;
                end
            end
        end
        else if (message_open_reg)
        begin
            res_cnt     = 3'd1;
            res_next[0] = '{kind: KIND_BYTE, status: ST_OK, offset: byte_pos,
                            data: 64'(in_byte_reg), last: last_byte};
            write_offset_next = wrap_add({1'b0, byte_pos}, SIZE_BITS'(1), size_eff);
            bytes_left_next   = last_byte ? 16'd0 : bytes_left_reg - 16'd1;
            if (last_byte)
            begin
                res_cnt            = 3'd2;
                head_position_next = head_commit;
                pending_adv_next   = '0;
                message_open_next  = 1'b0;
                res_next[1] = '{kind: KIND_COMMIT, status: ST_OK, offset: '0,
                                data: head_commit, last: 1'b1};
            end
        end
        // a stray payload byte with no message open is dropped
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_position_reg <= '0;
            write_offset_reg  <= '0;
            next_start_reg    <= '0;
            message_open_reg  <= 1'b0;
            bytes_left_reg    <= '0;
            pending_adv_reg   <= '0;
        end
        else if (load)
        begin
            head_position_reg <= head_position_next;
            write_offset_reg  <= write_offset_next;
            next_start_reg    <= next_start_next;
            message_open_reg  <= message_open_next;
            bytes_left_reg    <= bytes_left_next;
            pending_adv_reg   <= pending_adv_next;
        end
    end

    // ---------------- result buffer ----------------
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_rem_reg <= '0;
            res_idx_reg <= '0;
        end
        else if (load)
        begin
            res_rem_reg <= res_cnt;
            res_idx_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            res_rem_reg <= res_rem_reg - 3'd1;
            res_idx_reg <= res_idx_reg + 2'd1;
        end
    end

    assign res_out  = res_reg[res_idx_reg];
    assign m_tvalid = res_rem_reg != 3'd0;
    assign m_tuser  = res_out.kind;
    assign m_tlast  = res_out.last;
    assign m_tdata  = {6'd0, res_out.data, res_out.offset, res_out.status};

    // ---------------- assertions ----------------
    `FMRP_ASSERT(a_rem_bound, res_rem_reg <= 3'(MAX_RESULTS), "result count out of range")
    `FMRP_ASSERT_IMP(a_open_has_bytes, message_open_reg, bytes_left_reg != 16'd0, "open message with no bytes left")
    `FMRP_ASSERT(a_head_aligned, head_position_reg[2:0] == 3'd0, "head lost 8-byte alignment")
    `FMRP_ASSERT_IMP(a_open_has_adv, message_open_reg, pending_adv_reg >= ADV_BITS'(HEADER_BYTES + 8), "open message with short advance")

endmodule
